// ----- rtl/rta_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range table allocator package
// Shared types, codes and sizing constants for the range table cells,
// the remainder unit and the top level.
// ----------------------------------------------------------------------------
package rta_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int OWNER_BITS_DEF  = 16;
  localparam int ADDR_W          = 64;
  localparam int TAG_W           = 32;
  localparam int ATTR_W          = 8;
  localparam int OWNER_PORT_W    = 16;

  typedef enum logic [2:0] {
    FN_ADD       = 3'd0,
    FN_DEL_EXACT = 3'd1,
    FN_DEL_OWNER = 3'd2,
    FN_FIND      = 3'd3,
    FN_AVAIL     = 3'd4,
    FN_CLEAR     = 3'd5,
    FN_READ      = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_MORE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LOW,
    CELL_FROM_HIGH
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DELOWN,
    S_FCHK,
    S_FDIV,
    S_RESP
  } state_t;

  // One table entry without its owner tag (owner width is a parameter)
  typedef struct packed {
    logic [ADDR_W-1:0] rng_start;
    logic [ADDR_W-1:0] rng_end;
    logic [ATTR_W-1:0] attr;
    logic              shared;
    logic [TAG_W-1:0]  user;
  } entry_t;

  // Compare results a cell reports against the current request
  typedef struct packed {
    logic gt_end;
    logic exact;
    logic owner_hit;
    logic overlap;
  } cell_flags_t;

endpackage
`default_nettype wire

// ----- rtl/rta_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range table cell
// Holds one table entry, shifts to or from its neighbors and compares
// the entry against the current request.
// ----------------------------------------------------------------------------
module rta_cell #(
  parameter int OWNER_BITS = rta_pkg::OWNER_BITS_DEF
) (
  input  wire                           clk,
  input  rta_pkg::cell_cmd_t            cmd,
  input  rta_pkg::entry_t               new_entry,
  input  wire [OWNER_BITS-1:0]          new_owner,
  input  rta_pkg::entry_t               low_entry,
  input  wire [OWNER_BITS-1:0]          low_owner,
  input  rta_pkg::entry_t               high_entry,
  input  wire [OWNER_BITS-1:0]          high_owner,
  input  wire [rta_pkg::ADDR_W-1:0]     req_start,
  input  wire [rta_pkg::ADDR_W-1:0]     req_end,
  input  wire [OWNER_BITS-1:0]          req_owner,
  output rta_pkg::entry_t               entry,
  output logic [OWNER_BITS-1:0]         owner,
  output rta_pkg::cell_flags_t          flags
);
  import rta_pkg::*;

  entry_t                entry_r;
  logic [OWNER_BITS-1:0] owner_r;

  // Load, shift or hold the entry
  always_ff @(posedge clk) begin
    case (cmd)
      CELL_LOAD: begin
        entry_r <= new_entry;
        owner_r <= new_owner;
      end
      CELL_FROM_LOW: begin
        entry_r <= low_entry;
        owner_r <= low_owner;
      end
      CELL_FROM_HIGH: begin
        entry_r <= high_entry;
        owner_r <= high_owner;
      end
      default: begin
        entry_r <= entry_r;
        owner_r <= owner_r;
      end
    endcase
  end

  // Compare against the request
  always_comb begin
    flags.gt_end    = entry_r.rng_start > req_end;
    flags.owner_hit = owner_r == req_owner;
    flags.exact     = (entry_r.rng_start == req_start) && (entry_r.rng_end == req_end) &&
                      (owner_r == req_owner);
    flags.overlap   = !(((entry_r.rng_start > req_end) && (entry_r.rng_end > req_end)) ||
                        ((entry_r.rng_start < req_start) && (entry_r.rng_end < req_start)));
  end

  assign entry = entry_r;
  assign owner = owner_r;

endmodule
`default_nettype wire

// ----- rtl/rta_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring 64-by-32 remainder, one dividend bit per cycle; done is a
// registered pulse set together with the final remainder.
// ----------------------------------------------------------------------------
module rta_mod (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [rta_pkg::ADDR_W-1:0]    dividend,
  input  wire [rta_pkg::TAG_W-1:0]     divisor,
  output logic                         done,
  output logic [rta_pkg::TAG_W-1:0]    rem
);
  import rta_pkg::*;

  localparam int CNT_W = $clog2(ADDR_W);

  logic [ADDR_W-1:0] dvd_r;
  logic [TAG_W-1:0]  dsr_r;
  logic [TAG_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [TAG_W:0]    trial;
  logic [TAG_W:0]    diff;

  // Shift in one dividend bit and try to subtract
  always_comb begin
    trial = {rem_r, dvd_r[ADDR_W-1]};
    diff  = trial - {1'b0, dsr_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ADDR_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[ADDR_W-2:0], 1'b0};
      rem_r <= diff[TAG_W] ? trial[TAG_W-1:0] : diff[TAG_W-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ----- rtl/range_table_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Flow: add, delete_exact, is_available, clear and read pass from acceptance through
//   the execute state to the response state; delete_owner also removes entries one by one.
// find runs a gap check and then the 64-step remainder unit for each gap examined,
//   up to count+1 gaps. One transaction is worked on at a time.
// Reset clears the entry count, change stamp and handshake state; the cells
//   themselves are not cleared.
// ----------------------------------------------------------------------------
// Range table allocator
// Ordered range table kept in a row of cells that shift for insert and
// delete, with a sequencer for owner deletes and top-down free-gap search.
// ----------------------------------------------------------------------------
module range_table_allocator_top #(
  parameter int TABLE_DEPTH = rta_pkg::TABLE_DEPTH_DEF,
  parameter int OWNER_BITS  = rta_pkg::OWNER_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_func,
  input  wire  [63:0] in_start_req,
  input  wire  [63:0] in_end_req,
  input  wire  [31:0] in_length,
  input  wire  [31:0] in_alignment,
  input  wire  [7:0]  in_attributes,
  input  wire         in_shared_flag,
  input  wire  [15:0] in_owner,
  input  wire  [31:0] in_user_data,
  input  wire  [4:0]  in_index,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_found_start,
  output logic        out_available,
  output logic [63:0] out_entry_start,
  output logic [63:0] out_entry_end,
  output logic [7:0]  out_entry_attributes,
  output logic        out_entry_shared,
  output logic [15:0] out_entry_owner,
  output logic [31:0] out_entry_user_data,
  output logic [5:0]  out_entry_count,
  output logic [31:0] out_change_stamp
);
  import rta_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [TAG_W-1:0]        stamp_r, stamp_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]       top_r, top_nxt;

  logic [2:0]              req_func_r;
  logic [ADDR_W-1:0]       req_start_r;
  logic [ADDR_W-1:0]       req_end_r;
  logic [TAG_W-1:0]        req_len_r;
  logic [TAG_W-1:0]        req_align_r;
  logic [ATTR_W-1:0]       req_attr_r;
  logic                    req_shared_r;
  logic [OWNER_PORT_W-1:0] req_owner_r;
  logic [TAG_W-1:0]        req_user_r;
  logic [4:0]              req_idx_r;

  status_t                 res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]       res_found_r, res_found_nxt;
  logic                    res_avail_r, res_avail_nxt;
  entry_t                  res_entry_r, res_entry_nxt;
  logic [OWNER_PORT_W-1:0] res_owner_r, res_owner_nxt;

  logic                    out_valid_r;
  logic [2:0]              out_status_r;
  logic [ADDR_W-1:0]       out_found_r;
  logic                    out_avail_r;
  entry_t                  out_entry_r;
  logic [OWNER_PORT_W-1:0] out_owner_r;
  logic [5:0]              out_count_r;
  logic [TAG_W-1:0]        out_stamp_r;

  entry_t                  cell_entry [TABLE_DEPTH];
  logic [OWNER_BITS-1:0]   cell_owner [TABLE_DEPTH];
  cell_cmd_t               cell_cmd   [TABLE_DEPTH];
  cell_flags_t             cell_flags [TABLE_DEPTH];

  entry_t                  new_entry;
  logic [OWNER_BITS-1:0]   req_own;
  logic [IDX_W-1:0]        rd_sel;
  entry_t                  rd_entry;
  logic [OWNER_BITS-1:0]   rd_owner;
  logic [OWNER_PORT_W-1:0] rd_owner_port;

  logic [TABLE_DEPTH-1:0]  valid_vec;
  logic [TABLE_DEPTH-1:0]  gt_vec, exact_vec, own_vec, ovl_vec;
  logic                    gt_hit, exact_hit, own_hit;
  logic [CNT_W-1:0]        gt_pos, exact_pos, own_pos;

  logic                    in_fire, resp_fire;
  logic [ADDR_W-1:0]       lm1;
  logic                    gap_fail;
  logic [ADDR_W-1:0]       cand;
  logic                    cand_fail;
  logic                    div_start, div_done;
  logic [TAG_W-1:0]        div_rem;

  assign in_stall  = state_r != S_IDLE;
  assign in_fire   = in_valid && !in_stall;
  assign resp_fire = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  // Map the owner port onto the stored owner width
  generate
    if (OWNER_BITS <= OWNER_PORT_W) begin : g_own_narrow
      assign req_own = req_owner_r[OWNER_BITS-1:0];
    end else begin : g_own_wide
      assign req_own = OWNER_BITS'(req_owner_r);
    end
    if (OWNER_BITS >= OWNER_PORT_W) begin : g_rd_wide
      assign rd_owner_port = rd_owner[OWNER_PORT_W-1:0];
    end else begin : g_rd_narrow
      assign rd_owner_port = OWNER_PORT_W'(rd_owner);
    end
  endgenerate

  assign new_entry = '{rng_start: req_start_r, rng_end: req_end_r, attr: req_attr_r,
                       shared: req_shared_r, user: req_user_r};

  // Row of cells
  generate
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      entry_t                lo_e, hi_e;
      logic [OWNER_BITS-1:0] lo_o, hi_o;
      if (k == 0) begin : g_lo_edge
        assign lo_e = new_entry;
        assign lo_o = req_own;
      end else begin : g_lo
        assign lo_e = cell_entry[k-1];
        assign lo_o = cell_owner[k-1];
      end
      if (k == TABLE_DEPTH - 1) begin : g_hi_edge
        assign hi_e = cell_entry[k];
        assign hi_o = cell_owner[k];
      end else begin : g_hi
        assign hi_e = cell_entry[k+1];
        assign hi_o = cell_owner[k+1];
      end
      rta_cell #(.OWNER_BITS(OWNER_BITS)) u_cell (
        .clk        (clk),
        .cmd        (cell_cmd[k]),
        .new_entry  (new_entry),
        .new_owner  (req_own),
        .low_entry  (lo_e),
        .low_owner  (lo_o),
        .high_entry (hi_e),
        .high_owner (hi_o),
        .req_start  (req_start_r),
        .req_end    (req_end_r),
        .req_owner  (req_own),
        .entry      (cell_entry[k]),
        .owner      (cell_owner[k]),
        .flags      (cell_flags[k])
      );
    end
  endgenerate

  // Remainder unit for find alignment
  rta_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (top_r - lm1),
    .divisor  (req_align_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Gather cell flags and pick first hits
  always_comb begin
    gt_hit    = 1'b0;
    exact_hit = 1'b0;
    own_hit   = 1'b0;
    gt_pos    = count_r;
    exact_pos = '0;
    own_pos   = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      valid_vec[k] = CNT_W'(k) < count_r;
      gt_vec[k]    = cell_flags[k].gt_end && valid_vec[k];
      exact_vec[k] = cell_flags[k].exact && valid_vec[k];
      own_vec[k]   = cell_flags[k].owner_hit && valid_vec[k];
      ovl_vec[k]   = cell_flags[k].overlap && valid_vec[k];
    end
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (gt_vec[k]) begin
        gt_hit = 1'b1;
        gt_pos = CNT_W'(k);
      end
      if (exact_vec[k]) begin
        exact_hit = 1'b1;
        exact_pos = CNT_W'(k);
      end
      if (own_vec[k]) begin
        own_hit = 1'b1;
        own_pos = CNT_W'(k);
      end
    end
  end

  // Read port: entry below the gap during find, else the requested index
  always_comb begin
    if (state_r == S_FDIV) begin
      rd_sel = IDX_W'(ptr_r - 1'b1);
    end else begin
      rd_sel = IDX_W'(req_idx_r);
    end
    rd_entry = cell_entry[rd_sel];
    rd_owner = cell_owner[rd_sel];
  end

  // Gap checks for find
  always_comb begin
    lm1       = ADDR_W'(req_len_r) - 1'b1;
    gap_fail  = (top_r + lm1) < req_start_r;
    cand      = (top_r - lm1) - ADDR_W'(div_rem);
    cand_fail = (cand < req_start_r) || ((top_r - cand) < lm1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (req_func_r == FN_DEL_OWNER) begin
          state_nxt = S_DELOWN;
        end else if (req_func_r == FN_FIND && req_len_r != '0 && req_align_r != '0) begin
          state_nxt = S_FCHK;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_DELOWN: begin
        if (!own_hit) state_nxt = S_RESP;
      end
      S_FCHK: begin
        state_nxt = gap_fail ? S_RESP : S_FDIV;
      end
      S_FDIV: begin
        if (div_done) begin
          if (cand_fail || ptr_r == '0 || cand > rd_entry.rng_end) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_FCHK;
          end
        end
      end
      S_RESP: begin
        if (resp_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control per state
  always_comb begin
    count_nxt      = count_r;
    stamp_nxt      = stamp_r;
    ptr_nxt        = ptr_r;
    top_nxt        = top_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_avail_nxt  = res_avail_r;
    res_entry_nxt  = res_entry_r;
    res_owner_nxt  = res_owner_r;
    div_start      = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) cell_cmd[k] = CELL_HOLD;
    unique case (state_r)
      S_EXEC: begin
        res_status_nxt = ST_OK;
        res_found_nxt  = '0;
        res_avail_nxt  = 1'b0;
        res_entry_nxt  = '0;
        res_owner_nxt  = '0;
        case (req_func_r)
          FN_ADD: begin
            if (req_start_r > req_end_r) begin
              res_status_nxt = ST_INVALID;
            end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              // open a slot at the insert point and shift the rest up
              for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (CNT_W'(k) == gt_pos) cell_cmd[k] = CELL_LOAD;
                else if (CNT_W'(k) > gt_pos) cell_cmd[k] = CELL_FROM_LOW;
              end
              count_nxt = count_r + 1'b1;
              stamp_nxt = stamp_r + 1'b1;
            end
          end
          FN_DEL_EXACT: begin
            if (exact_hit) begin
              for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (CNT_W'(k) >= exact_pos) cell_cmd[k] = CELL_FROM_HIGH;
              end
              count_nxt = count_r - 1'b1;
              stamp_nxt = stamp_r + 1'b1;
            end else begin
              res_status_nxt = ST_NOT_FOUND;
            end
          end
          FN_DEL_OWNER: begin
            res_status_nxt = ST_OK;
          end
          FN_FIND: begin
            if (req_len_r == '0 || req_align_r == '0) begin
              res_status_nxt = ST_INVALID;
            end else begin
              res_status_nxt = ST_NOT_FOUND;
              ptr_nxt        = count_r;
              top_nxt        = req_end_r;
            end
          end
          FN_AVAIL: begin
            res_avail_nxt = ~|ovl_vec;
          end
          FN_CLEAR: begin
            count_nxt = '0;
          end
          FN_READ: begin
            if ((CNT_W + 5)'(req_idx_r) < (CNT_W + 5)'(count_r)) begin
              res_entry_nxt = rd_entry;
              res_owner_nxt = rd_owner_port;
            end else begin
              res_status_nxt = ST_NO_MORE;
            end
          end
          default: begin
            res_status_nxt = ST_INVALID;
          end
        endcase
      end
      S_DELOWN: begin
        // drop the first entry of the owner each cycle
        if (own_hit) begin
          for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (CNT_W'(k) >= own_pos) cell_cmd[k] = CELL_FROM_HIGH;
          end
          count_nxt = count_r - 1'b1;
          stamp_nxt = stamp_r + 1'b1;
        end
      end
      S_FCHK: begin
        if (!gap_fail) div_start = 1'b1;
      end
      S_FDIV: begin
        if (div_done && !cand_fail) begin
          if (ptr_r == '0 || cand > rd_entry.rng_end) begin
            res_status_nxt = ST_OK;
            res_found_nxt  = cand;
          end else begin
            // step down to the next gap
            top_nxt = rd_entry.rng_start - 1'b1;
            ptr_nxt = ptr_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      stamp_r <= stamp_nxt;
      if (resp_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    top_r        <= top_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_avail_r  <= res_avail_nxt;
    res_entry_r  <= res_entry_nxt;
    res_owner_r  <= res_owner_nxt;
    if (in_fire) begin
      req_func_r   <= in_func;
      req_start_r  <= in_start_req;
      req_end_r    <= in_end_req;
      req_len_r    <= in_length;
      req_align_r  <= in_alignment;
      req_attr_r   <= in_attributes;
      req_shared_r <= in_shared_flag;
      req_owner_r  <= in_owner;
      req_user_r   <= in_user_data;
      req_idx_r    <= in_index;
    end
    if (resp_fire) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_avail_r  <= res_avail_r;
      out_entry_r  <= res_entry_r;
      out_owner_r  <= res_owner_r;
      out_count_r  <= 6'(count_r);
      out_stamp_r  <= stamp_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_found_start      = out_found_r;
  assign out_available        = out_avail_r;
  assign out_entry_start      = out_entry_r.rng_start;
  assign out_entry_end        = out_entry_r.rng_end;
  assign out_entry_attributes = out_entry_r.attr;
  assign out_entry_shared     = out_entry_r.shared;
  assign out_entry_owner      = out_owner_r;
  assign out_entry_user_data  = out_entry_r.user;
  assign out_entry_count      = out_count_r;
  assign out_change_stamp     = out_stamp_r;

endmodule
`default_nettype wire
